/* rtl/flash_log_page_writer_top_defines.svh */
`ifndef FLASH_LOG_PAGE_WRITER_TOP_DEFINES_SVH
`define FLASH_LOG_PAGE_WRITER_TOP_DEFINES_SVH

// check that holds in the same cycle as its trigger
`define FLPW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that holds in the cycle after its trigger
`define FLPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/flpw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package flpw_pkg;

  localparam int ADDR_W     = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int REQ_W      = 3;
  localparam int CMD_W      = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DATA      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SYNC      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ_DONE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PAGE_READ = 3'd4;

  // flash commands
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROGRAM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES  = 2'd2;

  localparam logic [8:0]        PAGE_BYTES_RST   = 9'd256;
  localparam logic [4:0]        SECTOR_SHIFT_RST = 5'd12;
  localparam logic [ADDR_W-1:0] TOTAL_BYTES_RST  = 25'd2097152;
  localparam logic [4:0]        SHIFT_MIN        = 5'd8;
  localparam logic [4:0]        SHIFT_MAX        = 5'd16;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ERASE   = 2'd1,
    PH_PROGRAM = 2'd2,
    PH_RETRY   = 2'd3
  } flpw_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FLUSH
  } flpw_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic copy_step;
    logic finish;
  } flpw_cmd_t;

  typedef struct packed {
    logic copy_start;
    logic copy_last;
  } flpw_sts_t;

endpackage

`default_nettype wire

/* rtl/flpw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module flpw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire flpw_pkg::flpw_sts_t  sts,
  output flpw_pkg::flpw_cmd_t       cmd
);
  import flpw_pkg::*;

  flpw_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // output slot is free now or is emptied at this edge
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && slot_free) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.copy_start) begin
          state_nxt = ST_COPY;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last page byte lands in the buffer here
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = !((state_r == ST_IDLE) && slot_free);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/flpw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module flpw_dp #(
  parameter int FIFO_DEPTH = 1024,
  parameter int PAGE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire flpw_pkg::flpw_cmd_t                 cmd,
  output flpw_pkg::flpw_sts_t                      sts,
  input  wire logic [flpw_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [15:0]                         in_record_len,
  input  wire logic [7:0]                          in_data_byte,
  input  wire logic                                in_flash_accepts,
  input  wire logic [15:0]                         in_read_count,
  input  wire logic [7:0]                          in_page_index,
  input  wire logic                                cfg_we,
  input  wire logic [flpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [flpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [flpw_pkg::CMD_W-1:0]               out_command,
  output logic [23:0]                              out_flash_address,
  output logic [1:0]                               out_write_phase,
  output logic                                     out_log_full,
  output logic [23:0]                              out_read_address,
  output logic [7:0]                               out_page_byte,
  output logic [10:0]                              out_fifo_level
);
  import flpw_pkg::*;

  localparam int FW   = $clog2(FIFO_DEPTH);
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int PW   = $clog2(PAGE_DEPTH);
  localparam int PCW  = $clog2(PAGE_DEPTH + 1);
  localparam int MW   = (CW > PCW) ? CW : PCW;
  localparam int EW   = (PCW > 9) ? PCW : 9;
  localparam int IW   = (PW > 8) ? PW : 8;

  // configuration
  logic [8:0]        page_bytes_r;
  logic [4:0]        sector_shift_r;
  logic [ADDR_W-1:0] total_bytes_r;

  // captured request
  logic [REQ_W-1:0] req_r;
  logic [15:0]      rlen_r;
  logic [7:0]       dbyte_r;
  logic             acc_r;
  logic [15:0]      rcount_r;
  logic             pidx_ok_r;

  // block state
  logic [FW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic [ADDR_W-1:0] rp_r, rp_nxt;
  flpw_phase_t       phase_r, phase_nxt;
  logic              erased_r, erased_nxt;
  logic              full_r, full_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [PCW-1:0]    cnt_r, cnt_nxt;

  // memories and copy pipeline
  logic [7:0]    fifo_mem [FIFO_DEPTH];
  logic [7:0]    page_mem [PAGE_DEPTH];
  logic [7:0]    fifo_rd_r;
  logic [7:0]    page_rd_r;
  logic          wr_pend_r;
  logic [PW-1:0] wr_idx_r;

  // derived values
  logic [EW-1:0]     pb_ext;
  logic [PCW-1:0]    page_eff;
  logic [4:0]        shift_eff;
  logic              sector_edge;
  flpw_phase_t       ph_sel;
  logic [IW-1:0]     pidx_ext;
  logic [ADDR_W-1:0] rp_sum;
  logic              space_ok;
  logic              fifo_we;
  logic [CMD_W-1:0]  cmd_c;
  logic [CMD_W-1:0]  cmd_now;
  logic [7:0]        pbyte_c;

  assign pb_ext   = EW'(page_bytes_r);
  assign page_eff = (page_bytes_r == 9'd0) ? PCW'(1) :
                    (pb_ext > EW'(PAGE_DEPTH)) ? PCW'(PAGE_DEPTH) : PCW'(pb_ext);

  assign shift_eff = (sector_shift_r < SHIFT_MIN) ? SHIFT_MIN :
                     (sector_shift_r > SHIFT_MAX) ? SHIFT_MAX : sector_shift_r;

  assign sector_edge = (wa_r & ~({ADDR_W{1'b1}} << shift_eff)) == '0;

  always_comb begin
    if (!erased_r && sector_edge) begin
      ph_sel = PH_ERASE;
    end else if ((MW'(count_r) > MW'(page_eff)) && (phase_r != PH_RETRY)) begin
      ph_sel = PH_PROGRAM;
    end else begin
      ph_sel = phase_r;
    end
  end

  assign pidx_ext = IW'(in_page_index);
  assign rp_sum   = rp_r + ADDR_W'(rcount_r);
  assign space_ok = (wa_r < total_bytes_r) && ((total_bytes_r - wa_r) > ADDR_W'(rlen_r));

  assign sts.copy_start = (req_r == REQ_SYNC) && (ph_sel == PH_PROGRAM);
  assign sts.copy_last  = (cnt_r == page_eff - PCW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bytes_r   <= PAGE_BYTES_RST;
      sector_shift_r <= SECTOR_SHIFT_RST;
      total_bytes_r  <= TOTAL_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAGE_BYTES:   page_bytes_r   <= cfg_wdata[8:0];
        CFG_SECTOR_SHIFT: sector_shift_r <= cfg_wdata[4:0];
        CFG_TOTAL_BYTES:  total_bytes_r  <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= in_req_type;
      rlen_r    <= in_record_len;
      dbyte_r   <= in_data_byte;
      acc_r     <= in_flash_accepts;
      rcount_r  <= in_read_count;
      pidx_ok_r <= {1'b0, pidx_ext} < (IW + 1)'(PAGE_DEPTH);
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wa_nxt     = wa_r;
    rp_nxt     = rp_r;
    phase_nxt  = phase_r;
    erased_nxt = erased_r;
    full_nxt   = full_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    fifo_we    = 1'b0;
    cmd_c      = CMD_NONE;
    pbyte_c    = 8'd0;
    if (cmd.exec) begin
      cnt_nxt = '0;
      case (req_r)
        REQ_START: begin
          if (space_ok) begin
            rem_nxt  = rlen_r;
            full_nxt = 1'b0;
          end else begin
            rem_nxt  = 16'd0;
            full_nxt = 1'b1;
          end
        end
        REQ_DATA: begin
          if (rem_r != 16'd0) begin
            rem_nxt = rem_r - 16'd1;
            // byte still counts against the record when the fifo is full
            if (count_r < CW'(FIFO_DEPTH)) begin
              fifo_we   = 1'b1;
              head_nxt  = (head_r == FW'(FIFO_DEPTH - 1)) ? '0 : head_r + FW'(1);
              count_nxt = count_r + CW'(1);
            end
          end
        end
        REQ_SYNC: begin
          case (ph_sel)
            PH_ERASE: begin
              cmd_c = CMD_ERASE;
              if (acc_r) begin
                erased_nxt = 1'b1;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_ERASE;
              end
            end
            PH_PROGRAM, PH_RETRY: begin
              cmd_c = CMD_PROGRAM;
              if (acc_r) begin
                wa_nxt     = wa_r + ADDR_W'(page_eff);
                erased_nxt = 1'b0;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_RETRY;
              end
            end
            default: begin
              phase_nxt = ph_sel;
            end
          endcase
        end
        REQ_READ_DONE: begin
          rp_nxt = (rp_sum == wa_r) ? '0 : rp_sum;
        end
        REQ_PAGE_READ: begin
          pbyte_c = pidx_ok_r ? page_rd_r : 8'd0;
        end
        default: ;
      endcase
    end else if (cmd.copy_step) begin
      tail_nxt  = (tail_r == FW'(FIFO_DEPTH - 1)) ? '0 : tail_r + FW'(1);
      count_nxt = count_r - CW'(1);
      cnt_nxt   = cnt_r + PCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      wa_r      <= '0;
      rp_r      <= '0;
      phase_r   <= PH_IDLE;
      erased_r  <= 1'b0;
      full_r    <= 1'b0;
      rem_r     <= '0;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      wa_r      <= wa_nxt;
      rp_r      <= rp_nxt;
      phase_r   <= phase_nxt;
      erased_r  <= erased_nxt;
      full_r    <= full_nxt;
      rem_r     <= rem_nxt;
      cnt_r     <= cnt_nxt;
      wr_pend_r <= cmd.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cmd_r <= cmd_c;
    end
    if (cmd.copy_step) begin
      wr_idx_r <= cnt_r[PW-1:0];
    end
  end

  // byte fifo: one write port, registered read
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[head_r] <= dbyte_r;
    end
    if (cmd.copy_step) begin
      fifo_rd_r <= fifo_mem[tail_r];
    end
  end

  // page buffer: filled in the cycle after the fifo read
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      page_mem[wr_idx_r] <= fifo_rd_r;
    end
    if (cmd.capture) begin
      page_rd_r <= page_mem[pidx_ext[PW-1:0]];
    end
  end

  assign cmd_now = cmd.exec ? cmd_c : cmd_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_command       <= cmd_now;
      out_flash_address <= wa_nxt[23:0];
      out_write_phase   <= phase_nxt;
      out_log_full      <= full_nxt;
      out_read_address  <= rp_nxt[23:0];
      out_page_byte     <= pbyte_c;
      out_fifo_level    <= 11'(count_nxt);
    end
  end

endmodule

`default_nettype wire

/* rtl/flash_log_page_writer_top.sv */
// flow: a taken request is captured in IDLE and run in EXEC, which registers the result
// unless it is a sync that moves a page: that one walks its page through the fifo memory
// read port in COPY one byte a cycle, page being page_bytes clamped to 1..PAGE_DEPTH, and
// FLUSH registers its result; input is held off until the running request is done
// reset: synchronous active-low rst_n clears pointers, addresses, phase and flags and
// loads the configuration defaults; fifo and page buffer contents are left as they are
`timescale 1ns / 1ps
`default_nettype none

`include "flash_log_page_writer_top_defines.svh"

module flash_log_page_writer_top #(
  parameter int FIFO_DEPTH = 1024,
  parameter int PAGE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [flpw_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic [15:0]                         in_record_len,
  input  wire logic [7:0]                          in_data_byte,
  input  wire logic                                in_flash_accepts,
  input  wire logic [15:0]                         in_read_count,
  input  wire logic [7:0]                          in_page_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [flpw_pkg::CMD_W-1:0]               out_command,
  output logic [23:0]                              out_flash_address,
  output logic [1:0]                               out_write_phase,
  output logic                                     out_log_full,
  output logic [23:0]                              out_read_address,
  output logic [7:0]                               out_page_byte,
  output logic [10:0]                              out_fifo_level,
  input  wire logic                                cfg_we,
  input  wire logic [flpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [flpw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import flpw_pkg::*;

  flpw_cmd_t ctrl_cmd;
  flpw_sts_t dp_sts;

  flpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (ctrl_cmd)
  );

  flpw_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PAGE_DEPTH (PAGE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctrl_cmd),
    .sts               (dp_sts),
    .in_req_type       (in_req_type),
    .in_record_len     (in_record_len),
    .in_data_byte      (in_data_byte),
    .in_flash_accepts  (in_flash_accepts),
    .in_read_count     (in_read_count),
    .in_page_index     (in_page_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_command       (out_command),
    .out_flash_address (out_flash_address),
    .out_write_phase   (out_write_phase),
    .out_log_full      (out_log_full),
    .out_read_address  (out_read_address),
    .out_page_byte     (out_page_byte),
    .out_fifo_level    (out_fifo_level)
  );

  `FLPW_ASSERT_NEXT(a_take_then_exec, in_valid && !in_stall, ctrl_cmd.exec, "request taken but not executed")
  `FLPW_ASSERT_NEXT(a_finish_shows, ctrl_cmd.finish, out_valid, "finished request not presented")
  `FLPW_ASSERT_SAME(a_copy_blocks_in, ctrl_cmd.copy_step, in_stall, "request taken during page copy")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import flpw_pkg::*;

  localparam int FIFO_SLOTS     = 1024;
  localparam int PAGE_SLOTS     = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [15:0]      rlen;
    logic [7:0]       dbyte;
    logic             acc;
    logic [15:0]      rcount;
    logic [7:0]       pidx;
  } log_request_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [23:0]      faddr;
    logic [1:0]       phase;
    logic             full;
    logic [23:0]      raddr;
    logic [7:0]       pbyte;
    logic [10:0]      level;
  } flash_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [15:0]           in_record_len = '0;
  logic [7:0]            in_data_byte = '0;
  logic                  in_flash_accepts = 1'b0;
  logic [15:0]           in_read_count = '0;
  logic [7:0]            in_page_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CMD_W-1:0]      out_command;
  logic [23:0]           out_flash_address;
  logic [1:0]            out_write_phase;
  logic                  out_log_full;
  logic [23:0]           out_read_address;
  logic [7:0]            out_page_byte;
  logic [10:0]           out_fifo_level;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  flash_log_page_writer_top #(
    .FIFO_DEPTH(FIFO_SLOTS),
    .PAGE_DEPTH(PAGE_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_record_len(in_record_len),
    .in_data_byte(in_data_byte),
    .in_flash_accepts(in_flash_accepts),
    .in_read_count(in_read_count),
    .in_page_index(in_page_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_command(out_command),
    .out_flash_address(out_flash_address),
    .out_write_phase(out_write_phase),
    .out_log_full(out_log_full),
    .out_read_address(out_read_address),
    .out_page_byte(out_page_byte),
    .out_fifo_level(out_fifo_level),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the writer state
  logic [8:0]   cfg_page = PAGE_BYTES_RST;
  logic [4:0]   cfg_shift = SECTOR_SHIFT_RST;
  logic [24:0]  cfg_total = TOTAL_BYTES_RST;
  logic [7:0]   fifo_mem [FIFO_SLOTS];
  logic [9:0]   fifo_wr = '0;
  logic [9:0]   fifo_rd = '0;
  int           fifo_fill = 0;
  logic [7:0]   page_mem [PAGE_SLOTS];
  int           page_valid_len = 0;
  logic [24:0]  wr_addr = '0;
  logic [24:0]  rd_addr = '0;
  flpw_phase_t  wr_phase = PH_IDLE;
  logic         sector_clean = 1'b0;
  logic         log_full_flag = 1'b0;
  logic [15:0]  rec_left = '0;

  log_request_t  request_q[$];
  flash_status_t status_due[$];

  log_request_t  tx_cur;
  bit            tx_live;
  bit            tx_quiet = 1'b0;
  int            tx_gap = 0;
  bit            rx_quiet = 1'b0;
  int            rx_wait = 0;
  int            hold_left = 0;
  int            results_seen = 0;
  int            err_count = 0;
  int            quiet_cycles = 0;
  flash_status_t got;
  flash_status_t want;

  function automatic void finish_page(input int page);
    wr_addr = wr_addr + 25'(page);
    sector_clean = 1'b0;
    wr_phase = PH_IDLE;
  endfunction

  function automatic flash_status_t compute_status(input log_request_t r);
    int page;
    int shift;
    int i;
    logic [24:0] smask;
    logic [24:0] space;
    flash_status_t res;
    page = (cfg_page == 0) ? 1 : ((cfg_page > PAGE_SLOTS) ? PAGE_SLOTS : int'(cfg_page));
    shift = (cfg_shift < SHIFT_MIN) ? SHIFT_MIN :
            ((cfg_shift > SHIFT_MAX) ? SHIFT_MAX : int'(cfg_shift));
    smask = (25'd1 << shift) - 25'd1;
    res = '0;
    res.cmd = CMD_NONE;
    case (r.req)
      REQ_START: begin
        space = (wr_addr < cfg_total) ? cfg_total - wr_addr : '0;
        if (space > 25'(r.rlen)) begin
          rec_left = r.rlen;
          log_full_flag = 1'b0;
        end else begin
          rec_left = '0;
          log_full_flag = 1'b1;
        end
      end
      REQ_DATA: begin
        if (rec_left != 0) begin
          rec_left--;
          // a full fifo still uses up the record length
          if (fifo_fill < FIFO_SLOTS) begin
            fifo_mem[fifo_wr] = r.dbyte;
            fifo_wr = fifo_wr + 10'd1;
            fifo_fill++;
          end
        end
      end
      REQ_SYNC: begin
        if (!sector_clean && (wr_addr & smask) == '0) wr_phase = PH_ERASE;
        else if (fifo_fill > page && wr_phase != PH_RETRY) wr_phase = PH_PROGRAM;
        case (wr_phase)
          PH_ERASE: begin
            res.cmd = CMD_ERASE;
            if (r.acc) begin
              sector_clean = 1'b1;
              wr_phase = PH_IDLE;
            end
          end
          PH_PROGRAM: begin
            res.cmd = CMD_PROGRAM;
            for (i = 0; i < page; i++) begin
              page_mem[i] = fifo_mem[fifo_rd];
              fifo_rd = fifo_rd + 10'd1;
              fifo_fill--;
            end
            if (page > page_valid_len) page_valid_len = page;
            if (r.acc) finish_page(page);
            else wr_phase = PH_RETRY;
          end
          PH_RETRY: begin
            res.cmd = CMD_PROGRAM;
            if (r.acc) finish_page(page);
          end
          default: ;
        endcase
      end
      REQ_READ_DONE: begin
        rd_addr = rd_addr + 25'(r.rcount);
        if (rd_addr == wr_addr) rd_addr = '0;
      end
      REQ_PAGE_READ: begin
        res.pbyte = page_mem[r.pidx];
      end
      default: ;
    endcase
    res.faddr = wr_addr[23:0];
    res.phase = wr_phase;
    res.full = log_full_flag;
    res.raddr = rd_addr[23:0];
    res.level = 11'(fifo_fill);
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_live = in_valid;
      if (in_valid && !in_stall) begin
        status_due.push_back(compute_status(tx_cur));
        tx_live = 1'b0;
        if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        tx_gap = tx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (!tx_live) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (request_q.size() > 0) begin
          tx_cur = request_q.pop_front();
          tx_live = 1'b1;
          in_req_type <= tx_cur.req;
          in_record_len <= tx_cur.rlen;
          in_data_byte <= tx_cur.dbyte;
          in_flash_accepts <= tx_cur.acc;
          in_read_count <= tx_cur.rcount;
          in_page_index <= tx_cur.pidx;
        end
      end
      in_valid <= tx_live;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_command, out_flash_address, out_write_phase, out_log_full,
                out_read_address, out_page_byte, out_fifo_level};
        if (status_due.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("status %0d arrived with none pending", results_seen);
        end else begin
          want = status_due.pop_front();
          if (got.cmd !== want.cmd || got.faddr !== want.faddr || got.phase !== want.phase ||
              got.full !== want.full || got.raddr !== want.raddr ||
              got.pbyte !== want.pbyte || got.level !== want.level) begin
            err_count++;
            if (err_count <= 10)
              $display({"status %0d exp/got: cmd %0d/%0d addr %h/%h phase %0d/%0d ",
                        "full %0d/%0d raddr %h/%h byte %h/%h level %0d/%0d"},
                       results_seen, want.cmd, got.cmd, want.faddr, got.faddr,
                       want.phase, got.phase, want.full, got.full, want.raddr, got.raddr,
                       want.pbyte, got.pbyte, want.level, got.level);
          end
        end
        results_seen++;
        // long back-pressure so the writer fills up and stalls its input
        if (results_seen == 300 || results_seen == 1250) hold_left = HOLD_CYCLES;
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_quiet();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic queue_request(input log_request_t it);
    if (it.req == REQ_PAGE_READ) begin
      // page buffer must hold the entry before it is read
      do @(negedge clk);
      while (request_q.size() != 0 || in_valid);
      if (page_valid_len == 0) it.req = REQ_READ_DONE;
      else if (int'(it.pidx) >= page_valid_len) it.pidx = 8'($urandom_range(0, page_valid_len - 1));
    end else begin
      while (request_q.size() >= 2) @(negedge clk);
    end
    request_q.push_back(it);
  endtask

  task automatic put_request(input logic [REQ_W-1:0] req, input logic [15:0] rlen,
                             input logic [7:0] dbyte, input logic acc,
                             input logic [15:0] rcount, input logic [7:0] pidx);
    queue_request('{req, rlen, dbyte, acc, rcount, pidx});
  endtask

  task automatic program_regs(input logic [8:0] pg, input logic [4:0] sh,
                              input logic [24:0] tot, input bit from_write_addr);
    logic [24:0] total_val;
    wait_quiet();
    repeat (8) @(posedge clk);
    total_val = from_write_addr ? wr_addr + tot : tot;
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAGE_BYTES;
    cfg_wdata <= CFG_DATA_W'(pg);
    @(posedge clk);
    cfg_index <= CFG_SECTOR_SHIFT;
    cfg_wdata <= CFG_DATA_W'(sh);
    @(posedge clk);
    cfg_index <= CFG_TOTAL_BYTES;
    cfg_wdata <= total_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_page = pg;
    cfg_shift = sh;
    cfg_total = total_val;
  endtask

  function automatic log_request_t random_request(input int accept_pct);
    log_request_t it;
    it.req = REQ_W'($urandom_range(0, 7));
    it.rlen = 16'($urandom);
    it.dbyte = 8'($urandom);
    it.acc = ($urandom_range(0, 99) < accept_pct);
    it.rcount = 16'($urandom);
    it.pidx = 8'($urandom);
    return it;
  endfunction

  function automatic log_request_t side_request();
    log_request_t it;
    it = random_request(50);
    if ($urandom_range(0, 1) == 0) begin
      it.req = REQ_PAGE_READ;
    end else begin
      it.req = REQ_READ_DONE;
      case ($urandom_range(0, 2))
        0: it.rcount = 16'($urandom_range(0, 8));
        1: it.rcount = 16'(wr_addr - rd_addr);  // tends to land on the write address
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic random_traffic(input int n_items, input int max_rec,
                                input int sync_pct, input int accept_pct);
    int sent;
    int len;
    int k;
    log_request_t it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        it = random_request(accept_pct);
        it.req = REQ_START;
        if ($urandom_range(0, 19) != 0) it.rlen = 16'($urandom_range(1, max_rec));
        queue_request(it);
        sent++;
        len = (it.rlen > max_rec) ? $urandom_range(0, 8) : int'(it.rlen);
        for (k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(0, 99) < sync_pct) begin
            it = random_request(accept_pct);
            it.req = REQ_SYNC;
            queue_request(it);
            sent++;
          end else if ($urandom_range(0, 99) < 4) begin
            queue_request(side_request());
            sent++;
          end
          it = random_request(accept_pct);
          it.req = REQ_DATA;
          queue_request(it);
          sent++;
        end
      end else begin
        queue_request(random_request(accept_pct));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // tiny pages and capacity so refusals and programs come quickly
    program_regs(9'd2, 5'd8, 25'd20, 1'b0);
    put_request(REQ_START, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'hAA, 1'b0, 16'd0, 8'd0);        // stray byte
    put_request(REQ_START, 16'hFFFF, 8'h00, 1'b0, 16'd0, 8'd0);    // refused
    put_request(REQ_DATA, 16'd0, 8'h11, 1'b0, 16'd0, 8'd0);
    put_request(REQ_START, 16'd5, 8'h00, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'hFF, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'h5A, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'hA5, 1'b0, 16'd0, 8'd0);
    put_request(REQ_DATA, 16'd0, 8'h3C, 1'b0, 16'd0, 8'd0);
    put_request(REQ_SYNC, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);        // erase rejected
    put_request(REQ_SYNC, 16'd0, 8'h00, 1'b1, 16'd0, 8'd0);        // erase taken
    put_request(REQ_SYNC, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);        // program, then retry
    put_request(REQ_PAGE_READ, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);
    put_request(REQ_PAGE_READ, 16'd0, 8'h00, 1'b0, 16'd0, 8'd1);
    put_request(REQ_SYNC, 16'd0, 8'h00, 1'b1, 16'd0, 8'd0);
    put_request(REQ_SYNC, 16'd0, 8'h00, 1'b1, 16'd0, 8'd0);        // unaligned, program
    put_request(REQ_READ_DONE, 16'd0, 8'h00, 1'b0, 16'd0, 8'd0);
    put_request(REQ_READ_DONE, 16'd0, 8'h00, 1'b0, 16'd4, 8'd0);   // catches up, wraps to 0
    put_request(REQ_READ_DONE, 16'd0, 8'h00, 1'b0, 16'hFFFF, 8'd0);
    put_request(REQ_UNKNOWN, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF);
    put_request(REQ_START, 16'd15, 8'h00, 1'b0, 16'd0, 8'd0);      // just fits
    put_request(REQ_START, 16'd16, 8'h00, 1'b0, 16'd0, 8'd0);      // just misses

    // long records, flash never accepts: fifo runs full and drops bytes
    program_regs(9'd511, 5'd16, 25'h1FFFFFF, 1'b0);
    random_traffic(1200, 700, 1, 0);
    program_regs(9'd256, 5'd12, 25'h1FFFFFF, 1'b0);
    random_traffic(120, 40, 35, 80);
    program_regs(9'd1, 5'd8, 25'd0, 1'b0);
    random_traffic(80, 10, 30, 50);
    program_regs(9'd0, 5'd0, 25'd16777216, 1'b0);
    random_traffic(150, 12, 30, 60);
    program_regs(9'd3, 5'd31, 25'd60, 1'b1);
    random_traffic(150, 12, 30, 70);
    program_regs(9'd8, 5'd9, 25'd1000, 1'b1);
    random_traffic(150, 20, 25, 60);

    wait_quiet();
    repeat (PAGE_SLOTS + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* flash_log_page_writer_top.f */
+incdir+rtl
rtl/flpw_pkg.sv
rtl/flpw_ctrl.sv
rtl/flpw_dp.sv
rtl/flash_log_page_writer_top.sv
tb/tb.sv
